// ===== rtl/core/trial_division_factorizer_core_defines.svh =====
// assertion macros shared by the factorizer rtl
`ifndef TRIAL_DIVISION_FACTORIZER_CORE_DEFINES_SVH
`define TRIAL_DIVISION_FACTORIZER_CORE_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define TRDF_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define TRDF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/trdf_pkg.sv =====
// package with widths, result kinds and the divider status type
`default_nettype none

package trdf_pkg;

  // width of the number being factored
  localparam int VALUE_WIDTH = 32;
  // width of the value and factor ports
  localparam int FIELD_WIDTH = 32;
  // divider step counter width
  localparam int STEP_W = $clog2(VALUE_WIDTH);
  // result limit per input and its counter width
  localparam int MAX_RESULTS = 32;
  localparam int RES_CNT_W = $clog2(MAX_RESULTS);

  localparam logic [VALUE_WIDTH-1:0] FIRST_DIVISOR = VALUE_WIDTH'(2);

  // result kinds
  localparam logic [1:0] KIND_FACTOR   = 2'd0;
  localparam logic [1:0] KIND_COFACTOR = 2'd1;
  localparam logic [1:0] KIND_PRIME    = 2'd2;

  // divider status seen by the sequencer
  typedef struct packed {
    logic                   done;
    logic [VALUE_WIDTH-1:0] quotient;
    logic [VALUE_WIDTH-1:0] remainder;
  } div_res_t;

endpackage

`default_nettype wire

// ===== rtl/core/trdf_divider.sv =====
// shared restoring divider, one quotient bit per cycle
`default_nettype none

module trdf_divider import trdf_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   go,
  input  wire logic [VALUE_WIDTH-1:0] dividend,
  input  wire logic [VALUE_WIDTH-1:0] divisor,
  output div_res_t                    res
);

  logic                   running;
  logic [STEP_W-1:0]      step;
  logic [VALUE_WIDTH-1:0] rem;
  logic [VALUE_WIDTH-1:0] quo;
  logic                   done;

  logic [VALUE_WIDTH:0]   trial;
  logic [VALUE_WIDTH:0]   diff;
  logic                   fits;

  // shift in the next dividend bit and try the subtraction
  always_comb begin
    trial = {rem, quo[VALUE_WIDTH-1]};
    diff  = trial - {1'b0, divisor};
    fits  = !diff[VALUE_WIDTH];
  end

  // iteration control
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        running <= 1'b1;
      end else if (running && step == '0) begin
        running <= 1'b0;
        done    <= 1'b1;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (go) begin
      step <= STEP_W'(VALUE_WIDTH - 1);
      rem  <= '0;
      quo  <= dividend;
    end else if (running) begin
      step <= step - 1'b1;
      rem  <= fits ? diff[VALUE_WIDTH-1:0] : trial[VALUE_WIDTH-1:0];
      quo  <= {quo[VALUE_WIDTH-2:0], fits};
    end
  end

  assign res.done      = done;
  assign res.quotient  = quo;
  assign res.remainder = rem;

endmodule

`default_nettype wire

// ===== rtl/core/trial_division_factorizer_core.sv =====
// Trial-division factorizer. A number is taken when start is high and busy is low.
// Divisors run upward from 2; each prime factor comes out in ascending order with
// kind 0, then the remaining cofactor with kind 1, or the input itself with kind 2
// when it is prime; last marks the final word of a run. Input 1 gives no word and
// input 0 gives one cofactor word of 0. Each word is on factor/kind/last for exactly
// one cycle with strobe high, and the receiver cannot stall it. Every trial divisor
// runs on the one shared restoring divider: a launch state, one quotient bit per
// cycle, and a decision in the wait state. A prime near 2^32 needs about 65535
// trials; busy stays high for the whole run.
`default_nettype none
`include "trial_division_factorizer_core_defines.svh"

module trial_division_factorizer_core import trdf_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   start,
  output logic                        busy,
  input  wire logic [FIELD_WIDTH-1:0] value,
  output logic                        strobe,
  output logic [FIELD_WIDTH-1:0]      factor,
  output logic [1:0]                  kind,
  output logic                        last
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_LAUNCH = 2'd1;
  localparam logic [1:0] S_WAIT   = 2'd2;

  logic [1:0]             state;
  logic [VALUE_WIDTH-1:0] rest;
  logic [VALUE_WIDTH-1:0] divisor;
  logic [RES_CNT_W-1:0]   count;

  logic [VALUE_WIDTH-1:0] value_in;
  logic                   accept;
  logic                   finish;
  div_res_t               div_res;

  assign busy     = (state != S_IDLE);
  assign accept   = start && !busy;
  assign value_in = VALUE_WIDTH'(value);

  // stop when divisor squared exceeds the rest or the result limit is hit
  assign finish = (div_res.quotient < divisor) || (count == RES_CNT_W'(MAX_RESULTS - 1));

  trdf_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .go       (state == S_LAUNCH),
    .dividend (rest),
    .divisor  (divisor),
    .res      (div_res)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      strobe <= 1'b0;
    end else begin
      strobe <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept && value_in != VALUE_WIDTH'(1)) begin
            state <= S_LAUNCH;
          end
        end
        S_LAUNCH: begin
          state <= S_WAIT;
        end
        S_WAIT: begin
          if (div_res.done) begin
            if (finish) begin
              strobe <= 1'b1;
              state  <= S_IDLE;
            end else if (div_res.remainder == '0) begin
              strobe <= 1'b1;
              state  <= S_LAUNCH;
            end else begin
              state  <= S_LAUNCH;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // working value, divisor, result count and output word
  always_ff @(posedge clk) begin
    if (accept) begin
      rest    <= value_in;
      divisor <= FIRST_DIVISOR;
      count   <= '0;
    end else if (state == S_WAIT && div_res.done) begin
      if (finish) begin
        factor <= FIELD_WIDTH'(rest);
        kind   <= (count == '0 && rest != '0) ? KIND_PRIME : KIND_COFACTOR;
        last   <= 1'b1;
      end else if (div_res.remainder == '0) begin
        factor <= FIELD_WIDTH'(divisor);
        kind   <= KIND_FACTOR;
        last   <= 1'b0;
        rest   <= div_res.quotient;
        count  <= count + 1'b1;
      end else begin
        divisor <= divisor + 1'b1;
      end
    end
  end

  // checks
  `TRDF_ASSERT_NEXT(a_more_after_factor, clk, rst, strobe && !last, busy, "run ended early")
  `TRDF_ASSERT_SAME(a_idle_after_last, clk, rst, strobe && last, !busy, "busy on last word")
  `TRDF_ASSERT_SAME(a_prime_is_last, clk, rst, strobe && kind == KIND_PRIME, last, "open prime")
  `TRDF_ASSERT_SAME(a_factor_not_last, clk, rst, strobe && kind == KIND_FACTOR, !last, "last factor")

endmodule

`default_nettype wire
